[src/lsb_stego_message_extractor_top_defines.svh]
// assertion macros for the lsb stego message extractor
`ifndef LSB_STEGO_MESSAGE_EXTRACTOR_TOP_DEFINES_SVH
`define LSB_STEGO_MESSAGE_EXTRACTOR_TOP_DEFINES_SVH

`ifndef SYNTH
`define LSME_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lsme assertion failed");
`define LSME_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lsme assertion failed");
`else
`define LSME_ASSERT_IMPL(label, ante, cons)
`define LSME_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[src/lsme_pkg.sv]
// types, codes and helpers shared by the lsb stego message extractor
package lsme_pkg;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_MLEN,
      PH_MCHARS,
      PH_TLEN,
      PH_TEXT,
      PH_DONE
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE,
      KIND_ACCEPT,
      KIND_REJECT,
      KIND_EMPTY
   } kind_type;

   typedef enum logic [1:0] {
      CSR_HEADER_SKIP,
      CSR_MAGIC_LENGTH,
      CSR_MAGIC_WORD
   } csr_index_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] header_count;
      logic [2:0] bit_count;
      logic [7:0] shift_byte;
      logic [7:0] found_len;
      logic [7:0] char_count;
      logic       magic_ok;
      logic [7:0] msg_len;
   } parser_type;

   localparam parser_type PARSER_CLEAR = '{
      phase:        PH_HEADER,
      header_count: 8'd0,
      bit_count:    3'd0,
      shift_byte:   8'd0,
      found_len:    8'd0,
      char_count:   8'd0,
      magic_ok:     1'b1,
      msg_len:      8'd0
   };

   localparam logic [7:0]  HEADER_SKIP_RESET  = 8'd54;
   localparam logic [1:0]  MAGIC_LENGTH_RESET = 2'd2;
   localparam logic [15:0] MAGIC_WORD_RESET   = 16'h232A;

   function automatic logic [7:0] expected_char(input logic [7:0] idx,
                                                input logic [15:0] word);
      logic [7:0] ch;
      begin
         ch = 8'd0;
         if (idx == 8'd0) begin
            ch = word[15:8];
         end else if (idx == 8'd1) begin
            ch = word[7:0];
         end
         return ch;
      end
   endfunction

endpackage

[src/lsme_if.sv]
// request and response channel interfaces

interface lsme_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] cover_byte;
   logic       file_start;

   modport source(output valid, output cover_byte, output file_start, input ready);
   modport sink(input valid, input cover_byte, input file_start, output ready);
endinterface

interface lsme_rsp_if;
   import lsme_pkg::*;

   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   kind_type   kind;
   logic       last;

   modport source(output valid, output out_byte, output kind, output last, input ready);
   modport sink(input valid, input out_byte, input kind, input last, output ready);
endinterface

[src/lsb_stego_message_extractor_top.sv]
// lsb stego message extractor: cover byte stream in, hidden message results out
//
// Takes one cover byte per clock, sustained, while the response side keeps up. A
// transaction is captured in an input register, then decoded by the frame parser,
// and its result, if any, is written to the result register. The result register
// frees the request side: a new cover byte is taken while a finished result still
// waits, and the flow stalls only when a result must be written while the register
// is still full. file_start restarts the parser on its byte. Configuration writes
// apply from the next cycle and are meant for idle periods.
`include "lsb_stego_message_extractor_top_defines.svh"

module lsb_stego_message_extractor_top (
   input  logic              clock,
   input  logic              reset,
   lsme_req_if.sink          req_chan,
   lsme_rsp_if.source        rsp_chan,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);
   import lsme_pkg::*;

   logic [7:0]  header_skip_ff;
   logic [1:0]  magic_length_ff;
   logic [15:0] magic_word_ff;

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_start_ff;

   parser_type  parser_ff;
   parser_type  parser_in;
   parser_type  eff;

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [7:0]  rsp_byte_ff;
   kind_type    rsp_kind_ff;
   logic        rsp_last_ff;

   logic        has_result;
   logic [7:0]  res_byte;
   kind_type    res_kind;
   logic        res_last;

   logic        rsp_free;
   logic        step;
   logic        req_take;
   logic        skipping;
   logic        byte_done;
   phase_type   work_phase;
   logic [7:0]  sh;
   logic [7:0]  char_next;
   logic        match_ok;
   logic        mchars_ok;

   // handshake
   assign rsp_free       = !rsp_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && (!has_result || rsp_free);
   assign req_chan.ready = !in_valid_ff || step;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take || (in_valid_ff && !step);
   assign rsp_valid_in = (step && has_result) || (rsp_valid_ff && !rsp_chan.ready);

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.out_byte = rsp_byte_ff;
   assign rsp_chan.kind     = rsp_kind_ff;
   assign rsp_chan.last     = rsp_last_ff;

   // parser view after a file start
   always_comb begin
      if (in_start_ff) begin
         eff = PARSER_CLEAR;
      end else begin
         eff = parser_ff;
      end
   end

   assign skipping   = (eff.phase == PH_HEADER) && (eff.header_count < header_skip_ff);
   assign work_phase = (eff.phase == PH_HEADER) ? PH_MLEN : eff.phase;
   assign sh         = {eff.shift_byte[6:0], in_byte_ff[0]};
   assign byte_done  = (eff.phase != PH_DONE) && !skipping && (eff.bit_count == 3'd7);
   assign char_next  = eff.char_count + 8'd1;
   assign match_ok   = eff.magic_ok && (sh == expected_char(eff.char_count, magic_word_ff));
   assign mchars_ok  = match_ok && (eff.found_len == {6'd0, magic_length_ff});

   // next parser state
   always_comb begin
      parser_in = eff;
      if (eff.phase == PH_DONE) begin
         parser_in = eff;
      end else if (skipping) begin
         parser_in.header_count = eff.header_count + 8'd1;
      end else if (!byte_done) begin
         parser_in.phase      = work_phase;
         parser_in.shift_byte = sh;
         parser_in.bit_count  = eff.bit_count + 3'd1;
      end else begin
         parser_in.bit_count  = 3'd0;
         parser_in.shift_byte = 8'd0;
         case (work_phase)
            PH_MLEN: begin
               parser_in.found_len  = sh;
               parser_in.char_count = 8'd0;
               parser_in.magic_ok   = 1'b1;
               if (sh == 8'd0) begin
                  parser_in.phase = (magic_length_ff == 2'd0) ? PH_TLEN : PH_DONE;
               end else begin
                  parser_in.phase = PH_MCHARS;
               end
            end
            PH_MCHARS: begin
               parser_in.magic_ok   = match_ok;
               parser_in.char_count = char_next;
               if (char_next == eff.found_len) begin
                  parser_in.phase = mchars_ok ? PH_TLEN : PH_DONE;
               end else begin
                  parser_in.phase = PH_MCHARS;
               end
            end
            PH_TLEN: begin
               parser_in.msg_len    = sh;
               parser_in.char_count = 8'd0;
               parser_in.phase      = (sh == 8'd0) ? PH_DONE : PH_TEXT;
            end
            PH_TEXT: begin
               parser_in.char_count = char_next;
               parser_in.phase      = (char_next == eff.msg_len) ? PH_DONE : PH_TEXT;
            end
            default: begin
               parser_in.phase = PH_DONE;
            end
         endcase
      end
   end

   // result of the current transaction
   always_comb begin
      has_result = 1'b0;
      res_byte   = 8'd0;
      res_kind   = KIND_BYTE;
      res_last   = 1'b0;
      if (byte_done) begin
         case (work_phase)
            PH_MLEN: begin
               if (sh == 8'd0) begin
                  has_result = 1'b1;
                  res_kind   = (magic_length_ff == 2'd0) ? KIND_ACCEPT : KIND_REJECT;
                  res_last   = (magic_length_ff != 2'd0);
               end
            end
            PH_MCHARS: begin
               if (char_next == eff.found_len) begin
                  has_result = 1'b1;
                  res_kind   = mchars_ok ? KIND_ACCEPT : KIND_REJECT;
                  res_last   = !mchars_ok;
               end
            end
            PH_TLEN: begin
               if (sh == 8'd0) begin
                  has_result = 1'b1;
                  res_kind   = KIND_EMPTY;
                  res_last   = 1'b1;
               end
            end
            PH_TEXT: begin
               has_result = 1'b1;
               res_byte   = sh;
               res_kind   = KIND_BYTE;
               res_last   = (char_next == eff.msg_len);
            end
            default: begin
               has_result = 1'b0;
            end
         endcase
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         parser_ff    <= PARSER_CLEAR;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            parser_ff <= parser_in;
         end
      end
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_skip_ff  <= HEADER_SKIP_RESET;
         magic_length_ff <= MAGIC_LENGTH_RESET;
         magic_word_ff   <= MAGIC_WORD_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_HEADER_SKIP: begin
               header_skip_ff <= csr_wdata[7:0];
            end
            CSR_MAGIC_LENGTH: begin
               magic_length_ff <= csr_wdata[1:0];
            end
            CSR_MAGIC_WORD: begin
               magic_word_ff <= csr_wdata;
            end
            default: begin
               magic_word_ff <= magic_word_ff;
            end
         endcase
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff  <= req_chan.cover_byte;
         in_start_ff <= req_chan.file_start;
      end
      if (step && has_result) begin
         rsp_byte_ff <= res_byte;
         rsp_kind_ff <= res_kind;
         rsp_last_ff <= res_last;
      end
   end

   `LSME_ASSERT_IMPL(a_last_ends_file, step && has_result && res_last, parser_in.phase == PH_DONE)
   `LSME_ASSERT_IMPL(a_done_is_quiet, in_valid_ff && !in_start_ff && parser_ff.phase == PH_DONE, !has_result)
   `LSME_ASSERT_NEXT(a_blocked_holds, in_valid_ff && has_result && !rsp_free, $stable(parser_ff))
   `LSME_ASSERT_IMPL(a_accept_to_tlen, step && has_result && res_kind == KIND_ACCEPT, parser_in.phase == PH_TLEN)

endmodule

[bench/tb_lsb_stego_message_extractor_top.sv]
// testbench for the lsb stego message extractor: directed frames, random streams, stalls
module tb_lsb_stego_message_extractor_top;
   import lsme_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int RANDOM_ITEMS   = 40;

   typedef logic [7:0] byte_q_type[$];

   typedef enum logic [1:0] {
      RX_ALWAYS,
      RX_RANDOM,
      RX_PATTERN
   } rx_mode_type;

   typedef struct packed {
      logic [7:0] data;
      kind_type   kind;
      logic       last;
   } hidden_result_type;

   typedef struct packed {
      phase_type  phase;
      logic [7:0] skipped;
      logic [2:0] nbits;
      logic [7:0] acc;
      logic [7:0] seen_len;
      logic [7:0] idx;
      logic       magic_good;
      logic [7:0] text_len;
   } frame_parse_type;

   localparam frame_parse_type PARSE_CLEARED = '{
      phase:      PH_HEADER,
      skipped:    8'd0,
      nbits:      3'd0,
      acc:        8'd0,
      seen_len:   8'd0,
      idx:        8'd0,
      magic_good: 1'b1,
      text_len:   8'd0
   };

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   lsme_req_if req_chan();
   lsme_rsp_if rsp_chan();

   lsb_stego_message_extractor_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   frame_parse_type   frame_parse;
   logic [7:0]        skip_cfg;
   logic [1:0]        magic_len_cfg;
   logic [15:0]       magic_word_cfg;
   hidden_result_type pending_message_results[$];

   int          mismatches;
   int          items_sent;
   int          idle_cycles;
   int          burst_left;
   int          gap_max;
   bit          start_flag;
   bit          extreme_cover;
   bit          hold_request;
   rx_mode_type rx_mode;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [7:0] wanted_magic_char(input logic [7:0] pos);
      logic [7:0] ch;
      ch = 8'd0;
      if (pos == 8'd0) begin
         ch = magic_word_cfg[15:8];
      end else if (pos == 8'd1) begin
         ch = magic_word_cfg[7:0];
      end
      return ch;
   endfunction

   function automatic bit magic_verdict(output hidden_result_type res);
      res = '{data: 8'd0, kind: KIND_REJECT, last: 1'b1};
      if (frame_parse.magic_good && frame_parse.seen_len == {6'd0, magic_len_cfg}) begin
         frame_parse.phase = PH_TLEN;
         res.kind = KIND_ACCEPT;
         res.last = 1'b0;
      end else begin
         frame_parse.phase = PH_DONE;
      end
      return 1'b1;
   endfunction

   // advances the parser copy by one cover byte, returns 1 when a result is due
   function automatic bit decode_cover_byte(input logic [7:0] cb, input logic fs,
                                            output hidden_result_type res);
      logic [7:0] hb;
      res = '{data: 8'd0, kind: KIND_BYTE, last: 1'b0};
      if (fs) begin
         frame_parse = PARSE_CLEARED;
      end
      if (frame_parse.phase == PH_DONE) begin
         return 1'b0;
      end
      if (frame_parse.phase == PH_HEADER) begin
         if (frame_parse.skipped < skip_cfg) begin
            frame_parse.skipped++;
            return 1'b0;
         end
         frame_parse.phase = PH_MLEN;
      end
      frame_parse.acc = {frame_parse.acc[6:0], cb[0]};
      if (frame_parse.nbits != 3'd7) begin
         frame_parse.nbits++;
         return 1'b0;
      end
      frame_parse.nbits = 3'd0;
      hb = frame_parse.acc;
      frame_parse.acc = 8'd0;
      case (frame_parse.phase)
         PH_MLEN: begin
            frame_parse.seen_len = hb;
            frame_parse.idx = 8'd0;
            frame_parse.magic_good = 1'b1;
            if (hb == 8'd0) begin
               return magic_verdict(res);
            end
            frame_parse.phase = PH_MCHARS;
            return 1'b0;
         end
         PH_MCHARS: begin
            if (hb != wanted_magic_char(frame_parse.idx)) begin
               frame_parse.magic_good = 1'b0;
            end
            frame_parse.idx++;
            if (frame_parse.idx == frame_parse.seen_len) begin
               return magic_verdict(res);
            end
            return 1'b0;
         end
         PH_TLEN: begin
            frame_parse.text_len = hb;
            frame_parse.idx = 8'd0;
            if (hb == 8'd0) begin
               frame_parse.phase = PH_DONE;
               res.kind = KIND_EMPTY;
               res.last = 1'b1;
               return 1'b1;
            end
            frame_parse.phase = PH_TEXT;
            return 1'b0;
         end
         PH_TEXT: begin
            frame_parse.idx++;
            res.data = hb;
            res.last = (frame_parse.idx == frame_parse.text_len);
            if (res.last) begin
               frame_parse.phase = PH_DONE;
            end
            return 1'b1;
         end
         default: begin
            frame_parse.phase = PH_DONE;
            return 1'b0;
         end
      endcase
   endfunction

   // all driving tasks start and end at a falling edge
   task automatic send_cover(input logic [7:0] cb);
      hidden_result_type res;
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_chan.valid      <= 1'b1;
      req_chan.cover_byte <= cb;
      req_chan.file_start <= start_flag;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      if (decode_cover_byte(cb, start_flag, res)) begin
         pending_message_results.push_back(res);
      end
      start_flag = 1'b0;
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_hidden_byte(input logic [7:0] value);
      logic [7:0] cb;
      int i;
      for (i = 7; i >= 0; i--) begin
         if (extreme_cover) begin
            cb = value[i] ? 8'hFF : 8'h00;
         end else begin
            cb = 8'($urandom_range(0, 255));
            cb[0] = value[i];
         end
         send_cover(cb);
      end
   endtask

   task automatic send_frame(input int hdr_len, input byte_q_type hidden, input bit restart);
      int i;
      start_flag = restart;
      for (i = 0; i < hdr_len; i++) begin
         send_cover(8'($urandom_range(0, 255)));
      end
      foreach (hidden[k]) begin
         send_hidden_byte(hidden[k]);
      end
   endtask

   task automatic send_noise(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         start_flag = ($urandom_range(0, 15) == 0);
         send_cover(8'($urandom_range(0, 255)));
      end
   endtask

   function automatic byte_q_type build_frame(input int text_len);
      byte_q_type q;
      int i;
      q.push_back({6'd0, magic_len_cfg});
      for (i = 0; i < magic_len_cfg; i++) begin
         q.push_back(wanted_magic_char(i[7:0]));
      end
      q.push_back(text_len[7:0]);
      for (i = 0; i < text_len; i++) begin
         q.push_back(8'($urandom_range(0, 255)));
      end
      return q;
   endfunction

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (pending_message_results.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input csr_index_type reg_idx, input logic [15:0] value);
      csr_we    <= 1'b1;
      csr_index <= reg_idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
      case (reg_idx)
         CSR_HEADER_SKIP:  skip_cfg       = value[7:0];
         CSR_MAGIC_LENGTH: magic_len_cfg  = value[1:0];
         default:          magic_word_cfg = value;
      endcase
   endtask

   task automatic test_default_config();
      rx_mode = RX_ALWAYS;
      gap_max = 0;
      // no file_start on the first file
      send_frame(skip_cfg, build_frame(1), 1'b0);
      wait_idle();
   endtask

   task automatic test_extreme_cover();
      byte_q_type q;
      write_csr(CSR_HEADER_SKIP, 16'd0);
      extreme_cover = 1'b1;
      q = build_frame(0);
      void'(q.pop_back());
      q.push_back(8'd2);
      q.push_back(8'h00);
      q.push_back(8'hFF);
      send_frame(0, q, 1'b1);
      extreme_cover = 1'b0;
      wait_idle();
   endtask

   task automatic test_magic_decisions();
      rx_mode = RX_RANDOM;
      gap_max = 3;
      // zero magic length byte against a length of two, trailing byte ignored
      send_frame(0, '{8'd0, 8'h55}, 1'b1);
      wait_idle();
      write_csr(CSR_MAGIC_LENGTH, 16'd0);
      send_frame(0, '{8'd0, 8'd0}, 1'b1);
      wait_idle();
      write_csr(CSR_MAGIC_LENGTH, 16'd3);
      send_frame(0, build_frame(1), 1'b1);
      send_frame(0, '{8'd3, magic_word_cfg[15:8], magic_word_cfg[7:0], 8'h01,
                      8'd1, 8'h41}, 1'b1);
      wait_idle();
      write_csr(CSR_MAGIC_LENGTH, 16'd2);
      send_frame(0, '{8'd2, magic_word_cfg[15:8], ~magic_word_cfg[7:0], 8'd1, 8'h33},
                 1'b1);
      send_frame(0, '{8'd3, magic_word_cfg[15:8], magic_word_cfg[7:0], 8'd0, 8'd0},
                 1'b1);
      wait_idle();
      write_csr(CSR_MAGIC_LENGTH, 16'd1);
      write_csr(CSR_MAGIC_WORD, 16'h7E00);
      send_frame(0, '{8'd1, 8'h7E, 8'd2, 8'hA5, 8'h5A, 8'hFF}, 1'b1);
      wait_idle();
   endtask

   task automatic test_register_mid_file();
      logic [15:0] new_word;
      write_csr(CSR_HEADER_SKIP, 16'd2);
      write_csr(CSR_MAGIC_LENGTH, 16'd2);
      send_frame(skip_cfg, '{8'd2, magic_word_cfg[15:8]}, 1'b1);
      wait_idle();
      new_word = 16'($urandom_range(0, 65535));
      write_csr(CSR_MAGIC_WORD, new_word);
      send_frame(0, '{new_word[7:0], 8'd1, 8'h5A}, 1'b0);
      wait_idle();
   endtask

   task automatic test_long_header();
      rx_mode = RX_PATTERN;
      gap_max = 2;
      write_csr(CSR_HEADER_SKIP, 16'd255);
      write_csr(CSR_MAGIC_LENGTH, 16'd1);
      write_csr(CSR_MAGIC_WORD, 16'hFFFF);
      send_frame(skip_cfg, '{8'd1, 8'hFF, 8'd2, 8'h00, 8'hFF, 8'h12}, 1'b1);
      wait_idle();
   endtask

   task automatic test_output_stall();
      rx_mode = RX_ALWAYS;
      gap_max = 0;
      write_csr(CSR_HEADER_SKIP, 16'd0);
      write_csr(CSR_MAGIC_LENGTH, 16'd2);
      write_csr(CSR_MAGIC_WORD, MAGIC_WORD_RESET);
      hold_request = 1'b1;
      send_frame(0, build_frame(4), 1'b1);
      wait_idle();
   endtask

   task automatic test_random_streams();
      byte_q_type q;
      int base;
      int pick;
      int keep;
      int pos;
      base = items_sent;
      while (items_sent - base < RANDOM_ITEMS) begin
         wait_idle();
         write_csr(CSR_HEADER_SKIP, 16'(($urandom_range(0, 7) == 0) ?
                   $urandom_range(7, 20) : $urandom_range(0, 6)));
         write_csr(CSR_MAGIC_LENGTH, 16'($urandom_range(0, 3)));
         write_csr(CSR_MAGIC_WORD, 16'($urandom_range(0, 65535)));
         rx_mode = rx_mode_type'($urandom_range(0, 2));
         gap_max = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         repeat (2) begin
            pick = $urandom_range(0, 19);
            q = build_frame($urandom_range(0, 8));
            if (pick < 13) begin
               repeat ($urandom_range(0, 2)) q.push_back(8'($urandom_range(0, 255)));
               send_frame(skip_cfg, q, 1'b1);
            end else if (pick < 15) begin
               pos = $urandom_range(0, magic_len_cfg);
               q[pos] = q[pos] ^ (8'd1 << $urandom_range(0, 7));
               send_frame(skip_cfg, q, 1'b1);
            end else if (pick < 17) begin
               keep = $urandom_range(0, q.size() - 1);
               while (q.size() > keep) void'(q.pop_back());
               send_frame(skip_cfg, q, 1'b1);
            end else begin
               send_noise($urandom_range(8, 60));
            end
         end
      end
      wait_idle();
   endtask

   initial begin
      int rx_tick;
      rsp_chan.ready = 1'b0;
      rx_tick = 0;
      forever begin
         @(negedge clock);
         rx_tick++;
         if (hold_request) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            rsp_chan.ready <= 1'b1;
         end else begin
            case (rx_mode)
               RX_ALWAYS: rsp_chan.ready <= 1'b1;
               RX_RANDOM: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               default:   rsp_chan.ready <= ((rx_tick % 11) < 6);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      hidden_result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (pending_message_results.size() == 0) begin
            $display("%0t: unexpected result out_byte %02h kind %0d last %0d", $time,
                     rsp_chan.out_byte, rsp_chan.kind, rsp_chan.last);
            mismatches++;
         end else begin
            want = pending_message_results.pop_front();
            if (rsp_chan.out_byte !== want.data) begin
               $display("%0t: out_byte expected %02h actual %02h", $time, want.data,
                        rsp_chan.out_byte);
               mismatches++;
            end
            if (rsp_chan.kind !== want.kind) begin
               $display("%0t: kind expected %0d actual %0d", $time, want.kind,
                        rsp_chan.kind);
               mismatches++;
            end
            if (rsp_chan.last !== want.last) begin
               $display("%0t: last expected %0d actual %0d", $time, want.last,
                        rsp_chan.last);
               mismatches++;
            end
         end
      end
   end

   // no transaction on either side for too long
   always @(posedge clock) begin
      if (reset || (req_chan.valid === 1'b1 && req_chan.ready === 1'b1) ||
          (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.cover_byte = 8'd0;
      req_chan.file_start = 1'b0;
      csr_we              = 1'b0;
      csr_index           = CSR_HEADER_SKIP;
      csr_wdata           = 16'd0;
      frame_parse         = PARSE_CLEARED;
      skip_cfg            = HEADER_SKIP_RESET;
      magic_len_cfg       = MAGIC_LENGTH_RESET;
      magic_word_cfg      = MAGIC_WORD_RESET;
      mismatches          = 0;
      items_sent          = 0;
      idle_cycles         = 0;
      burst_left          = 0;
      gap_max             = 0;
      start_flag          = 1'b0;
      extreme_cover       = 1'b0;
      hold_request        = 1'b0;
      rx_mode             = RX_ALWAYS;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_default_config();
      test_extreme_cover();
      test_magic_decisions();
      test_register_mid_file();
      test_long_header();
      test_output_stall();
      test_random_streams();

      if (mismatches == 0 && pending_message_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
